// ===== rtl/capdu_pkg.sv =====
package capdu_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [2:0] NoOffset    = 3'd0;
  localparam logic [2:0] ShortOffset = 3'd5;
  localparam logic [2:0] ExtOffset   = 3'd7;

  localparam logic [16:0] ShortLeZero = 17'd256;
  localparam logic [16:0] ExtLeZero   = 17'd65536;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SHORT_HDR   = 3'd1,
    ERR_SHORT_LEN   = 3'd2,
    ERR_SHORT_EXT   = 3'd3,
    ERR_EXT_LC_ZERO = 3'd4,
    ERR_EXT_LEN     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    CASE_1  = 3'd0,
    CASE_2S = 3'd1,
    CASE_3S = 3'd2,
    CASE_4S = 3'd3,
    CASE_2E = 3'd4,
    CASE_3E = 3'd5,
    CASE_4E = 3'd6
  } case_t;

  // Everything the classifier needs about one finished APDU.
  typedef struct packed {
    logic [CountW-1:0] size;
    logic [3:0][7:0]   hdr;
    logic [2:0][7:0]   len;
    logic [7:0]        cur;
    logic [7:0]        prev;
  } snap_t;

  typedef struct packed {
    logic        valid_res;
    err_t        error_code;
    case_t       apdu_case;
    logic        extended;
    logic [15:0] data_count;
    logic [16:0] expected_count;
    logic [7:0]  class_byte;
    logic [7:0]  instruction_byte;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [2:0]  data_offset;
  } res_t;

endpackage

// ===== rtl/capdu_if.sv =====
interface capdu_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface capdu_rsp_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [2:0]  error_code;
  logic [2:0]  apdu_case;
  logic        extended;
  logic [15:0] data_count;
  logic [16:0] expected_count;
  logic [7:0]  class_byte;
  logic [7:0]  instruction_byte;
  logic [7:0]  param_one;
  logic [7:0]  param_two;
  logic [2:0]  data_offset;

  modport source (
    output valid, output valid_res, output error_code, output apdu_case,
    output extended, output data_count, output expected_count,
    output class_byte, output instruction_byte, output param_one,
    output param_two, output data_offset, input ready
  );
  modport sink (
    input valid, input valid_res, input error_code, input apdu_case,
    input extended, input data_count, input expected_count,
    input class_byte, input instruction_byte, input param_one,
    input param_two, input data_offset, output ready
  );
endinterface

// ===== rtl/capdu_capture.sv =====
module capdu_capture (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output capdu_pkg::snap_t    snap
);

  logic [capdu_pkg::CountW-1:0] byte_count;
  logic [3:0][7:0]              header_bytes;
  logic [2:0][7:0]              length_bytes;
  logic [7:0]                   previous_byte;

  // The snapshot already holds the current byte at its header or length slot.
  always_comb begin
    snap.size = (byte_count != capdu_pkg::CountMax) ?
                byte_count + 1'b1 : capdu_pkg::CountMax;
    for (int k = 0; k < 4; k++) begin
      snap.hdr[k] = (byte_count == capdu_pkg::CountW'(k)) ? data_byte : header_bytes[k];
    end
    for (int k = 0; k < 3; k++) begin
      snap.len[k] = (byte_count == capdu_pkg::CountW'(k + 4)) ? data_byte : length_bytes[k];
    end
    snap.cur  = data_byte;
    snap.prev = previous_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      header_bytes  <= '0;
      length_bytes  <= '0;
      previous_byte <= '0;
    end else if (accept) begin
      if (last) begin
        byte_count    <= '0;
        header_bytes  <= '0;
        length_bytes  <= '0;
        previous_byte <= '0;
      end else begin
        byte_count    <= snap.size;
        header_bytes  <= snap.hdr;
        length_bytes  <= snap.len;
        previous_byte <= data_byte;
      end
    end
  end

endmodule

// ===== rtl/capdu_classify.sv =====
module capdu_classify (
  input  capdu_pkg::snap_t snap,
  output capdu_pkg::res_t  res
);

  logic [16:0]      size;
  logic [7:0]       l1;
  logic [15:0]      l2;
  logic [15:0]      l3;
  logic [16:0]      l1_ext;
  logic [16:0]      l2_ext;
  capdu_pkg::err_t  err;
  capdu_pkg::case_t cs;
  logic             ext;
  logic [15:0]      nc;
  logic [16:0]      ne;
  logic [2:0]       ofs;

  assign size   = snap.size;
  assign l1     = snap.len[0];
  assign l2     = {snap.len[1], snap.len[2]};
  assign l3     = {snap.prev, snap.cur};
  assign l1_ext = {9'd0, l1};
  assign l2_ext = {1'b0, l2};

  always_comb begin
    err = capdu_pkg::ERR_NONE;
    cs  = capdu_pkg::CASE_1;
    ext = 1'b0;
    nc  = '0;
    ne  = '0;
    ofs = capdu_pkg::NoOffset;
    if (size < 17'd4) begin
      err = capdu_pkg::ERR_SHORT_HDR;
    end else if (size == 17'd4) begin
      cs = capdu_pkg::CASE_1;
    end else if (size == 17'd5) begin
      cs = capdu_pkg::CASE_2S;
      ne = (l1 == 8'd0) ? capdu_pkg::ShortLeZero : l1_ext;
    end else if (l1 != 8'd0) begin
      if (size == l1_ext + 17'd5) begin
        cs  = capdu_pkg::CASE_3S;
        nc  = {8'd0, l1};
        ofs = capdu_pkg::ShortOffset;
      end else if (size == l1_ext + 17'd6) begin
        cs  = capdu_pkg::CASE_4S;
        nc  = {8'd0, l1};
        ofs = capdu_pkg::ShortOffset;
        ne  = (snap.cur == 8'd0) ? capdu_pkg::ShortLeZero : {9'd0, snap.cur};
      end else begin
        err = capdu_pkg::ERR_SHORT_LEN;
      end
    end else if (size < 17'd7) begin
      err = capdu_pkg::ERR_SHORT_EXT;
    end else if (size == 17'd7) begin
      cs  = capdu_pkg::CASE_2E;
      ext = 1'b1;
      ne  = (l2 == 16'd0) ? capdu_pkg::ExtLeZero : l2_ext;
    end else if (l2 == 16'd0) begin
      err = capdu_pkg::ERR_EXT_LC_ZERO;
    end else if (size == l2_ext + 17'd7) begin
      cs  = capdu_pkg::CASE_3E;
      ext = 1'b1;
      nc  = l2;
      ofs = capdu_pkg::ExtOffset;
    end else if (size == l2_ext + 17'd9) begin
      cs  = capdu_pkg::CASE_4E;
      ext = 1'b1;
      nc  = l2;
      ofs = capdu_pkg::ExtOffset;
      ne  = (l3 == 16'd0) ? capdu_pkg::ExtLeZero : {1'b0, l3};
    end else begin
      err = capdu_pkg::ERR_EXT_LEN;
    end

    // A failed parse reports only its error code.
    res = '0;
    res.error_code = err;
    if (err == capdu_pkg::ERR_NONE) begin
      res.valid_res        = 1'b1;
      res.apdu_case        = cs;
      res.extended         = ext;
      res.data_count       = nc;
      res.expected_count   = ne;
      res.class_byte       = snap.hdr[0];
      res.instruction_byte = snap.hdr[1];
      res.param_one        = snap.hdr[2];
      res.param_two        = snap.hdr[3];
      res.data_offset      = ofs;
    end
  end

endmodule

// ===== rtl/command_apdu_parser_unit.sv =====
// Command APDU parser.
// The cmd channel takes one byte of a command APDU per transfer, with last
// set on the final byte. The rsp channel gives one result per APDU: validity,
// error code, case, extended flag, Nc, Ne, the four header bytes and the data
// offset. Bytes without last produce nothing on rsp.
// A byte is taken in every cycle unless cmd stalls as described below; the
// byte counter and the captured header and length bytes are updated as each
// transfer completes. The final byte's snapshot is registered, classified
// by one level of compare logic and registered again as its result.
// A full result can wait on rsp while new bytes keep flowing in; cmd only
// stalls when both the snapshot register and the result register are full
// and rsp is not ready.
// Reset (rst, synchronous) clears the byte counter, the captured bytes and
// both valid flags, so the next byte is taken as the first of a new APDU.
module command_apdu_parser_unit (
  input logic          clk,
  input logic          rst,
  capdu_cmd_if.sink    cmd,
  capdu_rsp_if.source  rsp
);

  capdu_pkg::snap_t snap;
  capdu_pkg::snap_t snap_q;
  logic             snap_valid;
  capdu_pkg::res_t  res;
  capdu_pkg::res_t  res_q;
  logic             out_valid;
  logic             out_free;
  logic             accept;

  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = !snap_valid || out_free;
  assign accept    = cmd.valid && cmd.ready;

  capdu_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (cmd.data_byte),
    .last      (cmd.last),
    .snap      (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && cmd.last) begin
      snap_valid <= 1'b1;
    end else if (out_free) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.last) begin
      snap_q <= snap;
    end
  end

  capdu_classify u_classify (
    .snap (snap_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      res_q <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.valid_res        = res_q.valid_res;
  assign rsp.error_code       = res_q.error_code;
  assign rsp.apdu_case        = res_q.apdu_case;
  assign rsp.extended         = res_q.extended;
  assign rsp.data_count       = res_q.data_count;
  assign rsp.expected_count   = res_q.expected_count;
  assign rsp.class_byte       = res_q.class_byte;
  assign rsp.instruction_byte = res_q.instruction_byte;
  assign rsp.param_one        = res_q.param_one;
  assign rsp.param_two        = res_q.param_two;
  assign rsp.data_offset      = res_q.data_offset;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomBytes = 1820;

  // Kinds of APDU the random generator builds.
  typedef enum int {
    F_CASE_1, F_CASE_2S, F_CASE_3S, F_CASE_4S, F_CASE_2E, F_CASE_3E, F_CASE_4E,
    F_BAD_HDR, F_BAD_SHORT_LEN, F_BAD_SHORT_EXT, F_BAD_LC_ZERO, F_BAD_EXT_LEN,
    F_NOISE
  } frame_kind_t;

  typedef struct {
    logic [7:0]      b;
    logic            l;
    bit              typed;
    capdu_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  always #6 clk = ~clk;

  capdu_cmd_if cmd_bus ();
  capdu_rsp_if rsp_bus ();

  command_apdu_parser_unit DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // Predictor state: mirrors the parser's byte counter and captured bytes.
  logic [16:0] apdu_len;
  logic [7:0]  hdr_bytes [4];
  logic [7:0]  len_bytes [3];
  logic [7:0]  prior_byte;

  capdu_pkg::res_t pending_verdicts [$];
  stim_row_t       directed_rows [$];
  logic [7:0]      frame [$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned apdus_sent = 0;
  int unsigned case_hits [7];
  int unsigned err_hits [6];
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 26);
  endfunction

  function automatic void clear_capture();
    apdu_len = '0;
    prior_byte = '0;
    for (int i = 0; i < 4; i++) hdr_bytes[i] = '0;
    for (int i = 0; i < 3; i++) len_bytes[i] = '0;
  endfunction

  function automatic capdu_pkg::res_t classify_apdu(input int unsigned sz,
                                                    input logic [7:0] cur,
                                                    input logic [7:0] prv);
    capdu_pkg::res_t  r;
    capdu_pkg::err_t  e;
    capdu_pkg::case_t c;
    bit               x;
    int unsigned      nc;
    int unsigned      ne;
    int unsigned      l1;
    int unsigned      l2;
    int unsigned      l3;
    logic [2:0]       ofs;
    e = capdu_pkg::ERR_NONE;
    c = capdu_pkg::CASE_1;
    x = 1'b0;
    nc = 0;
    ne = 0;
    ofs = capdu_pkg::NoOffset;
    if (sz < 4) begin
      e = capdu_pkg::ERR_SHORT_HDR;
    end else if (sz == 4) begin
      c = capdu_pkg::CASE_1;
    end else begin
      l1 = 32'(len_bytes[0]);
      if (sz == 5) begin
        c = capdu_pkg::CASE_2S;
        ne = (l1 == 0) ? 32'(capdu_pkg::ShortLeZero) : l1;
      end else if (l1 != 0) begin
        if (sz == 5 + l1) begin
          c = capdu_pkg::CASE_3S; nc = l1; ofs = capdu_pkg::ShortOffset;
        end else if (sz == 6 + l1) begin
          c = capdu_pkg::CASE_4S; nc = l1; ofs = capdu_pkg::ShortOffset;
          ne = (cur == 8'd0) ? 32'(capdu_pkg::ShortLeZero) : 32'(cur);
        end else begin
          e = capdu_pkg::ERR_SHORT_LEN;
        end
      end else if (sz < 7) begin
        e = capdu_pkg::ERR_SHORT_EXT;
      end else begin
        l2 = 32'({len_bytes[1], len_bytes[2]});
        if (sz == 7) begin
          c = capdu_pkg::CASE_2E; x = 1'b1;
          ne = (l2 == 0) ? 32'(capdu_pkg::ExtLeZero) : l2;
        end else if (l2 == 0) begin
          e = capdu_pkg::ERR_EXT_LC_ZERO;
        end else if (sz == 7 + l2) begin
          c = capdu_pkg::CASE_3E; x = 1'b1; nc = l2; ofs = capdu_pkg::ExtOffset;
        end else if (sz == 9 + l2) begin
          l3 = 32'({prv, cur});
          c = capdu_pkg::CASE_4E; x = 1'b1; nc = l2; ofs = capdu_pkg::ExtOffset;
          ne = (l3 == 0) ? 32'(capdu_pkg::ExtLeZero) : l3;
        end else begin
          e = capdu_pkg::ERR_EXT_LEN;
        end
      end
    end
    r = '0;
    r.error_code = e;
    err_hits[e]++;
    if (e == capdu_pkg::ERR_NONE) begin
      case_hits[c]++;
      r.valid_res = 1'b1;
      r.apdu_case = c;
      r.extended = x;
      r.data_count = nc[15:0];
      r.expected_count = ne[16:0];
      r.class_byte = hdr_bytes[0];
      r.instruction_byte = hdr_bytes[1];
      r.param_one = hdr_bytes[2];
      r.param_two = hdr_bytes[3];
      r.data_offset = ofs;
    end
    return r;
  endfunction

  // Advances the predictor by one accepted byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic l,
                                    output capdu_pkg::res_t r);
    int unsigned pos;
    logic [16:0] sz;
    pos = 32'(apdu_len);
    r = '0;
    if (pos < 4) hdr_bytes[pos[1:0]] = b;
    else if (pos < 7) len_bytes[2'(pos - 4)] = b;
    sz = (apdu_len != capdu_pkg::CountMax) ? apdu_len + 17'd1 : capdu_pkg::CountMax;
    if (l) begin
      r = classify_apdu(32'(sz), b, prior_byte);
      clear_capture();
      return 1'b1;
    end
    apdu_len = sz;
    prior_byte = b;
    return 1'b0;
  endfunction

  function automatic capdu_pkg::res_t mk_res(input bit v, input capdu_pkg::err_t e,
                                             input capdu_pkg::case_t c, input bit x,
                                             input logic [15:0] nc, input logic [16:0] ne,
                                             input logic [7:0] cla, input logic [7:0] ins,
                                             input logic [7:0] p1, input logic [7:0] p2,
                                             input logic [2:0] ofs);
    capdu_pkg::res_t r;
    r.valid_res = v;
    r.error_code = e;
    r.apdu_case = c;
    r.extended = x;
    r.data_count = nc;
    r.expected_count = ne;
    r.class_byte = cla;
    r.instruction_byte = ins;
    r.param_one = p1;
    r.param_two = p2;
    r.data_offset = ofs;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic l, input bit typed,
                                  input capdu_pkg::res_t want);
    stim_row_t row;
    row.b = b;
    row.l = l;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d field %s is %0h, expected %0h",
                              results_seen, name, got, want));
  endtask

  // Offers one byte, holding valid across back-to-back transfers.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input capdu_pkg::res_t want);
    capdu_pkg::res_t r;
    if (take_gap()) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
      while (take_gap()) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.data_byte <= b;
    cmd_bus.last <= l;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, l, r)) begin
      apdus_sent++;
      pending_verdicts.push_back(typed ? want : r);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++)
      send_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
  endtask

  function automatic int unsigned short_len();
    return ($urandom_range(19) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
  endfunction

  function automatic int unsigned ext_len();
    return ($urandom_range(49) == 0) ? $urandom_range(256, 700) : $urandom_range(1, 24);
  endfunction

  function automatic void push_random(input int unsigned n);
    repeat (n) frame.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void push_le(input bit ext);
    // Zero Le values are biased up so the 256 and 65536 readings show up often.
    if ($urandom_range(5) == 0) begin
      frame.push_back(8'h00);
      if (ext) frame.push_back(8'h00);
    end else begin
      push_random(ext ? 2 : 1);
    end
  endfunction

  function automatic void build_frame(input frame_kind_t kind);
    int unsigned lc;
    int unsigned k;
    frame.delete();
    if (kind == F_BAD_HDR) begin
      push_random($urandom_range(1, 3));
    end else if (kind == F_NOISE) begin
      push_random($urandom_range(1, 40));
    end else begin
      push_random(4);
      case (kind)
        F_CASE_2S: push_le(1'b0);
        F_CASE_3S, F_CASE_4S: begin
          lc = short_len();
          frame.push_back(lc[7:0]);
          push_random(lc);
          if (kind == F_CASE_4S) push_le(1'b0);
        end
        F_CASE_2E: begin
          frame.push_back(8'h00);
          push_le(1'b1);
        end
        F_CASE_3E, F_CASE_4E: begin
          lc = ext_len();
          frame.push_back(8'h00);
          frame.push_back(lc[15:8]);
          frame.push_back(lc[7:0]);
          push_random(lc);
          if (kind == F_CASE_4E) push_le(1'b1);
        end
        F_BAD_SHORT_LEN: begin
          lc = $urandom_range(1, 255);
          do k = $urandom_range(1, 24); while (k == lc || k == lc + 1);
          frame.push_back(lc[7:0]);
          push_random(k);
        end
        F_BAD_SHORT_EXT: begin
          frame.push_back(8'h00);
          push_random(1);
        end
        F_BAD_LC_ZERO: begin
          frame.push_back(8'h00);
          frame.push_back(8'h00);
          frame.push_back(8'h00);
          push_random($urandom_range(1, 12));
        end
        F_BAD_EXT_LEN: begin
          lc = $urandom_range(1, 65535);
          do k = $urandom_range(1, 24); while (k == lc || k == lc + 2);
          frame.push_back(8'h00);
          frame.push_back(lc[15:8]);
          frame.push_back(lc[7:0]);
          push_random(k);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return F_CASE_1;
    if (r < 16) return F_CASE_2S;
    if (r < 30) return F_CASE_3S;
    if (r < 42) return F_CASE_4S;
    if (r < 48) return F_CASE_2E;
    if (r < 58) return F_CASE_3E;
    if (r < 68) return F_CASE_4E;
    if (r < 72) return F_BAD_HDR;
    if (r < 78) return F_BAD_SHORT_LEN;
    if (r < 82) return F_BAD_SHORT_EXT;
    if (r < 86) return F_BAD_LC_ZERO;
    if (r < 92) return F_BAD_EXT_LEN;
    return F_NOISE;
  endfunction

  // Result side: random back-pressure plus requested long hold-offs.
  initial begin : rsp_side
    int unsigned hold_left;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    capdu_pkg::res_t want;
    if (rst === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_verdicts.pop_front();
        check_field("valid_res", rsp_bus.valid_res, want.valid_res);
        check_field("error_code", rsp_bus.error_code, want.error_code);
        check_field("apdu_case", rsp_bus.apdu_case, want.apdu_case);
        check_field("extended", rsp_bus.extended, want.extended);
        check_field("data_count", rsp_bus.data_count, want.data_count);
        check_field("expected_count", rsp_bus.expected_count, want.expected_count);
        check_field("class_byte", rsp_bus.class_byte, want.class_byte);
        check_field("instruction_byte", rsp_bus.instruction_byte, want.instruction_byte);
        check_field("param_one", rsp_bus.param_one, want.param_one);
        check_field("param_two", rsp_bus.param_two, want.param_two);
        check_field("data_offset", rsp_bus.data_offset, want.data_offset);
      end
    end
  end

  // Ends the run when neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if (rst !== 1'b0 || (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_verdicts.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned frames_done;
    rst <= 1'b1;
    cmd_bus.valid <= 1'b0;
    cmd_bus.data_byte <= '0;
    cmd_bus.last <= 1'b0;
    clear_capture();
    for (int i = 0; i < 7; i++) case_hits[i] = 0;
    for (int i = 0; i < 6; i++) err_hits[i] = 0;

    // Single byte: too short for a header, every field but the error code zero.
    add_row(8'hFF, 1'b1, 1'b1,
            mk_res(1'b0, capdu_pkg::ERR_SHORT_HDR, capdu_pkg::CASE_1, 1'b0, '0, '0,
                   '0, '0, '0, '0, capdu_pkg::NoOffset));
    // Header only, extreme header values echoed back.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b1, 1'b1,
            mk_res(1'b1, capdu_pkg::ERR_NONE, capdu_pkg::CASE_1, 1'b0, '0, '0,
                   8'h00, 8'hFF, 8'h80, 8'h7F, capdu_pkg::NoOffset));
    // Short Le of zero reads as 256.
    add_row(8'h5A, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'hFE, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1,
            mk_res(1'b1, capdu_pkg::ERR_NONE, capdu_pkg::CASE_2S, 1'b0, '0,
                   capdu_pkg::ShortLeZero, 8'h5A, 8'hA5, 8'h01, 8'hFE,
                   capdu_pkg::NoOffset));
    // Lc of 2 with only one byte after it: short length mismatch, fields wiped.
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h03, 1'b0, 1'b0, '0);
    add_row(8'h04, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b1, 1'b1,
            mk_res(1'b0, capdu_pkg::ERR_SHORT_LEN, capdu_pkg::CASE_1, 1'b0, '0, '0,
                   '0, '0, '0, '0, capdu_pkg::NoOffset));
    // Shortest case 3s, left to the predictor.
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'hCA, 1'b0, 1'b0, '0);
    add_row(8'h9F, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h33, 1'b1, 1'b0, '0);
    // Extended Le of zero reads as 65536.
    add_row(8'hC0, 1'b0, 1'b0, '0);
    add_row(8'h3C, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, '0);
    add_row(8'hEE, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1,
            mk_res(1'b1, capdu_pkg::ERR_NONE, capdu_pkg::CASE_2E, 1'b1, '0,
                   capdu_pkg::ExtLeZero, 8'hC0, 8'h3C, 8'h11, 8'hEE,
                   capdu_pkg::NoOffset));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].l, directed_rows[i].typed,
                directed_rows[i].want);

    // An APDU averages about 17 bytes, so the random part spans about 100 APDUs.
    frames_done = 0;
    while (bytes_sent < directed_rows.size() + RandomBytes) begin
      if (frames_done == 20 || frames_done == 90) hold_req = 1'b1;
      steady = (frames_done >= 40 && frames_done < 70);
      build_frame(pick_kind());
      send_frame();
      frames_done++;
    end
    steady = 1'b0;
    cmd_bus.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d APDUs; cases 1/2s/3s/4s/2e/3e/4e: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             bytes_sent, apdus_sent, case_hits[0], case_hits[1], case_hits[2],
             case_hits[3], case_hits[4], case_hits[5], case_hits[6]);
    $display("error codes 1..5: %0d/%0d/%0d/%0d/%0d, %0d results checked",
             err_hits[1], err_hits[2], err_hits[3], err_hits[4], err_hits[5],
             results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
